@@ sv/syct_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// syct_pkg
// Shared constants, codes and types of the sorted year counter table.
// ----------------------------------------------------------------------------
package syct_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int MAX_SPAN    = 64;
    localparam int MAX_RESULTS = 64;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int K_W   = $clog2(MAX_RESULTS + 1);

    // longest zero-filled listing, in years
    localparam int SPAN_LIMIT = (MAX_SPAN < MAX_RESULTS) ? MAX_SPAN : MAX_RESULTS;

    // field widths
    localparam int FUNC_W   = 2;
    localparam int YEAR_W   = 16;
    localparam int SUM_W    = 64;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 6;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RANGE  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_FILL   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_UPDATED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NONE     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_BAD      = 3'd5;

    // one result beat as built by the sequencer
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [YEAR_W-1:0]   year;
        logic [SUM_W-1:0]    value;
        logic [CNT_W-1:0]    pos;
        logic                last;
    } beat_t;

endpackage
`default_nettype wire

@@ sv/syct_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// syct_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module syct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                          aclk,
    input  wire logic                                          wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                              wr_data,
    input  wire logic                                          rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port, read data held while rd_en is low
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ sv/sorted_year_counter_table_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_year_counter_table_unit
// Table of (year, 64-bit sum) entries kept in year order in two RAMs. Adds
// accumulate into or insert an entry; lookups, range listings and zero-filled
// range listings report entries one beat at a time.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    func, year, end_year, add_value
//   m_       out  m_valid/m_ready    status, out_year, out_value, position, last
//
// Every request runs a binary search: each halving step reads a probe entry
// and compares it, then the lower-bound entry is read before the first beat.
// Insert reads and rewrites each entry moved up; listings read the table once per beat.
// Each table access is a registered RAM read followed by a state that uses
// the read data. One request is worked on at a time.
// Reset clears the entry count, the sequencer state and the valid flags; the RAMs are not cleared.
// A stalled output register holds the sequencer; the next request is taken
// while the final beat of the previous one still waits.
// ----------------------------------------------------------------------------
module sorted_year_counter_table_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic        [syct_pkg::FUNC_W-1:0]   s_func,
    input  wire logic        [syct_pkg::YEAR_W-1:0]   s_year,
    input  wire logic        [syct_pkg::YEAR_W-1:0]   s_end_year,
    input  wire logic signed [syct_pkg::SUM_W-1:0]    s_add_value,

    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic             [syct_pkg::STATUS_W-1:0] m_status,
    output logic             [syct_pkg::YEAR_W-1:0]   m_out_year,
    output logic signed      [syct_pkg::SUM_W-1:0]    m_out_value,
    output logic             [syct_pkg::POS_W-1:0]    m_position,
    output logic                                      m_last
);

    localparam int CNT_W  = syct_pkg::CNT_W;
    localparam int IDX_W  = syct_pkg::IDX_W;
    localparam int K_W    = syct_pkg::K_W;
    localparam int YEAR_W = syct_pkg::YEAR_W;
    localparam int SUM_W  = syct_pkg::SUM_W;

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SRCH = 4'd1;
    localparam logic [3:0] ST_SCMP = 4'd2;
    localparam logic [3:0] ST_PCMP = 4'd3;
    localparam logic [3:0] ST_SHRD = 4'd4;
    localparam logic [3:0] ST_SHWR = 4'd5;
    localparam logic [3:0] ST_INS  = 4'd6;
    localparam logic [3:0] ST_RCHK = 4'd7;
    localparam logic [3:0] ST_RCMP = 4'd8;
    localparam logic [3:0] ST_RFIN = 4'd9;
    localparam logic [3:0] ST_ZRD  = 4'd10;
    localparam logic [3:0] ST_ZCMP = 4'd11;

    logic [3:0] state_reg, state_next;

    // request registers
    logic [syct_pkg::FUNC_W-1:0] func_reg;
    logic [YEAR_W-1:0]           yr_reg;
    logic [YEAR_W-1:0]           ey_reg;
    logic [SUM_W-1:0]            addv_reg;

    // search and walk registers
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  mid_reg, mid_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [YEAR_W-1:0] zy_reg, zy_next;

    // held range beat, sent once the next entry shows whether it is the last
    logic              pend_valid_reg, pend_valid_next;
    logic [YEAR_W-1:0] pend_year_reg, pend_year_next;
    logic [SUM_W-1:0]  pend_value_reg, pend_value_next;
    logic [CNT_W-1:0]  pend_pos_reg, pend_pos_next;

    // output register
    logic                          out_valid_reg;
    logic [syct_pkg::STATUS_W-1:0] out_status_reg;
    logic [YEAR_W-1:0]             out_year_reg;
    logic [SUM_W-1:0]              out_value_reg;
    logic [syct_pkg::POS_W-1:0]    out_pos_reg;
    logic                          out_last_reg;

    syct_pkg::beat_t em;
    logic            out_free;

    // ram ports
    logic              wr_en, rd_en;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic [YEAR_W-1:0] wr_year, rd_year;
    logic [SUM_W-1:0]  wr_sum, rd_sum;

    // helpers
    logic [CNT_W-1:0]  mid_calc;
    logic [CNT_W-1:0]  idx_m1;
    logic              lo_in, idx_in, hit, full, bad_span, zmatch;
    logic [YEAR_W:0]   span;
    logic [SUM_W-1:0]  new_sum;

    syct_ram #(.WIDTH(YEAR_W), .DEPTH(syct_pkg::TABLE_DEPTH)) u_year_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_year),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_year)
    );

    syct_ram #(.WIDTH(SUM_W), .DEPTH(syct_pkg::TABLE_DEPTH)) u_sum_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_sum),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_sum)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_ready;

    // datapath helpers
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_m1   = idx_reg - CNT_W'(1);
    assign lo_in    = (lo_reg < count_reg);
    assign idx_in   = (idx_reg < count_reg);
    assign hit      = lo_in && (rd_year == yr_reg);
    assign full     = (count_reg >= CNT_W'(syct_pkg::TABLE_DEPTH));
    assign span     = {1'b0, ey_reg} - {1'b0, yr_reg};
    assign bad_span = span[YEAR_W] || (span >= (YEAR_W+1)'(syct_pkg::SPAN_LIMIT));
    assign zmatch   = idx_in && (rd_year == zy_reg);
    assign new_sum  = rd_sum + addv_reg;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        zy_next         = zy_reg;
        pend_valid_next = pend_valid_reg;
        pend_year_next  = pend_year_reg;
        pend_value_next = pend_value_reg;
        pend_pos_next   = pend_pos_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_year         = yr_reg;
        wr_sum          = addv_reg;
        em              = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = ST_SRCH;
                end
            end

            // issue the next search probe or the final lower-bound read
            ST_SRCH: begin
                if (lo_reg < hi_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = mid_calc[IDX_W-1:0];
                    mid_next   = mid_calc;
                    state_next = ST_SCMP;
                end else begin
                    rd_en      = lo_in;
                    rd_addr    = lo_reg[IDX_W-1:0];
                    state_next = ST_PCMP;
                end
            end

            ST_SCMP: begin
                if (rd_year < yr_reg) begin
                    lo_next = mid_reg + CNT_W'(1);
                end else begin
                    hi_next = mid_reg;
                end
                state_next = ST_SRCH;
            end

            // dispatch on the request with the lower bound known
            ST_PCMP: begin
                unique case (func_reg)
                    syct_pkg::FUNC_ADD: begin
                        if (hit) begin
                            if (out_free) begin
                                wr_en      = 1'b1;
                                wr_addr    = lo_reg[IDX_W-1:0];
                                wr_sum     = new_sum;
                                em         = '{1'b1, syct_pkg::STAT_UPDATED, yr_reg,
                                               new_sum, lo_reg, 1'b1};
                                state_next = ST_IDLE;
                            end
                        end else if (full) begin
                            if (out_free) begin
                                em         = '{1'b1, syct_pkg::STAT_FULL, yr_reg,
                                               '0, count_reg, 1'b1};
                                state_next = ST_IDLE;
                            end
                        end else begin
                            idx_next   = count_reg;
                            state_next = ST_SHRD;
                        end
                    end
                    syct_pkg::FUNC_LOOKUP: begin
                        if (out_free) begin
                            em = hit ? '{1'b1, syct_pkg::STAT_FOUND, yr_reg, rd_sum,
                                         lo_reg, 1'b1}
                                     : '{1'b1, syct_pkg::STAT_NONE, yr_reg, '0,
                                         lo_reg, 1'b1};
                            state_next = ST_IDLE;
                        end
                    end
                    syct_pkg::FUNC_RANGE: begin
                        idx_next        = lo_reg;
                        k_next          = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_RCHK;
                    end
                    default: begin
                        if (bad_span) begin
                            if (out_free) begin
                                em         = '{1'b1, syct_pkg::STAT_BAD, yr_reg,
                                               '0, '0, 1'b1};
                                state_next = ST_IDLE;
                            end
                        end else begin
                            idx_next   = lo_reg;
                            zy_next    = yr_reg;
                            state_next = ST_ZRD;
                        end
                    end
                endcase
            end

            // move entries above the insert point up by one
            ST_SHRD: begin
                if (idx_reg > lo_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_m1[IDX_W-1:0];
                    state_next = ST_SHWR;
                end else begin
                    state_next = ST_INS;
                end
            end

            ST_SHWR: begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[IDX_W-1:0];
                wr_year    = rd_year;
                wr_sum     = rd_sum;
                idx_next   = idx_m1;
                state_next = ST_SHRD;
            end

            ST_INS: begin
                if (out_free) begin
                    wr_en      = 1'b1;
                    wr_addr    = lo_reg[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                    em         = '{1'b1, syct_pkg::STAT_INSERTED, yr_reg, addv_reg,
                                   lo_reg, 1'b1};
                    state_next = ST_IDLE;
                end
            end

            // range listing walk
            ST_RCHK: begin
                if (idx_in && (k_reg < K_W'(syct_pkg::MAX_RESULTS))) begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg[IDX_W-1:0];
                    state_next = ST_RCMP;
                end else begin
                    state_next = ST_RFIN;
                end
            end

            ST_RCMP: begin
                if (rd_year <= ey_reg) begin
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            em = '{1'b1, syct_pkg::STAT_FOUND, pend_year_reg,
                                   pend_value_reg, pend_pos_reg, 1'b0};
                        end
                        pend_valid_next = 1'b1;
                        pend_year_next  = rd_year;
                        pend_value_next = rd_sum;
                        pend_pos_next   = idx_reg;
                        k_next          = k_reg + K_W'(1);
                        idx_next        = idx_reg + CNT_W'(1);
                        state_next      = ST_RCHK;
                    end
                end else begin
                    state_next = ST_RFIN;
                end
            end

            ST_RFIN: begin
                if (out_free) begin
                    em = pend_valid_reg
                         ? '{1'b1, syct_pkg::STAT_FOUND, pend_year_reg, pend_value_reg,
                             pend_pos_reg, 1'b1}
                         : '{1'b1, syct_pkg::STAT_NONE, yr_reg, '0, '0, 1'b1};
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            // zero-filled listing, one year per beat
            ST_ZRD: begin
                rd_en      = idx_in;
                rd_addr    = idx_reg[IDX_W-1:0];
                state_next = ST_ZCMP;
            end

            ST_ZCMP: begin
                if (out_free) begin
                    em = zmatch ? '{1'b1, syct_pkg::STAT_FOUND, zy_reg, rd_sum,
                                    idx_reg, (zy_reg == ey_reg)}
                                : '{1'b1, syct_pkg::STAT_NONE, zy_reg, '0,
                                    idx_reg, (zy_reg == ey_reg)};
                    if (zmatch) begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                    if (zy_reg == ey_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        zy_next    = zy_reg + YEAR_W'(1);
                        state_next = ST_ZRD;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            if (out_free) begin
                out_valid_reg <= em.valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg <= s_func;
            yr_reg   <= s_year;
            ey_reg   <= s_end_year;
            addv_reg <= s_add_value;
        end
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        idx_reg        <= idx_next;
        k_reg          <= k_next;
        zy_reg         <= zy_next;
        pend_year_reg  <= pend_year_next;
        pend_value_reg <= pend_value_next;
        pend_pos_reg   <= pend_pos_next;
        if (out_free && em.valid) begin
            out_status_reg <= em.status;
            out_year_reg   <= em.year;
            out_value_reg  <= em.value;
            out_pos_reg    <= syct_pkg::POS_W'(em.pos);
            out_last_reg   <= em.last;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_status    = out_status_reg;
    assign m_out_year  = out_year_reg;
    assign m_out_value = out_value_reg;
    assign m_position  = out_pos_reg;
    assign m_last      = out_last_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(syct_pkg::TABLE_DEPTH))
        else $error("entry count above table depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 ((count_reg == $past(count_reg)) ||
             (count_reg == $past(count_reg) + CNT_W'(1))))
        else $error("entry count moved by more than one");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !wr_en)
        else $error("table write while idle");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while a request is in progress");

endmodule
`default_nettype wire
